FILE: hw/rtl/tglc437_pkg.sv
// Package with coordinate defaults, control codes and the code page 437 lookup.
package tglc437_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int CP_BITS = 21;
   localparam int OUT_COORD_BITS = 16;
   localparam logic [7:0] TAB_WIDTH_RESET = 8'd8;
   localparam logic [7:0] UNMAPPED_GLYPH = 8'h3F;

   localparam logic [CP_BITS-1:0] CP_TAB = 21'h09;
   localparam logic [CP_BITS-1:0] CP_NEWLINE = 21'h0A;
   localparam logic [CP_BITS-1:0] CP_RETURN = 21'h0D;
   localparam logic [CP_BITS-1:0] CP_SPACE = 21'h20;
   localparam logic [CP_BITS-1:0] CP_TILDE = 21'h7E;

   localparam logic [15:0] UPPER_PAGE [128] = '{
      16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
      16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
      16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
      16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
      16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
      16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
      16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
      16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
      16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
      16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
      16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
      16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
      16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
      16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
      16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
      16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
   };

   localparam logic [15:0] LOWER_PAGE [31] = '{
      16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022, 16'h25D8,
      16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C, 16'h25BA,
      16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8, 16'h2191,
      16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC
   };

   // Reverse lookup of a code point into a glyph index, 63 when unmapped.
   function automatic logic [7:0] to_cp437(input logic [CP_BITS-1:0] cp);
      logic [7:0] g;
      g = UNMAPPED_GLYPH;
      for (int i = 127; i >= 0; i--) begin
         if ({5'd0, UPPER_PAGE[i]} == cp) g = 8'(8'h80 + i);
      end
      case (cp)
         21'h2302: g = 8'h7F;
         21'h03B2: g = 8'hE1;
         21'h03A0, 21'h220F: g = 8'hE3;
         21'h2211: g = 8'hE4;
         21'h03BC: g = 8'hE6;
         21'h2126: g = 8'hEA;
         21'h00F0, 21'h2202: g = 8'hEB;
         21'h2205, 21'h03D5, 21'h2300, 21'h00F8: g = 8'hED;
         21'h2208, 21'h20AC: g = 8'hEE;
         default: ;
      endcase
      for (int i = 30; i >= 0; i--) begin
         if ({5'd0, LOWER_PAGE[i]} == cp) g = 8'(i + 1);
      end
      if (cp >= CP_SPACE && cp <= CP_TILDE) g = cp[7:0];
      if (cp == '0) g = 8'd0;
      return g;
   endfunction

endpackage

FILE: hw/rtl/text_glyph_layout_cp437.sv
// Text layout block: cursor tracking, tab stops and code page 437 glyph mapping.
// An accepted item passes through ST_UPD to ST_OUT, where the result is offered; a tab first
// passes through ST_DIV, a restoring divider stepping one quotient bit a cycle, and ST_MUL.
// One item at a time: the next item is taken the cycle after the result is delivered.
// Reset (synchronous, active high) clears cursor and extents and sets the tab width to 8.
module text_glyph_layout_cp437 #(
   parameter int COORD_BITS = tglc437_pkg::COORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // code_point[20:0], zero pad
   input  logic        req_tuser,   // start_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // glyph, cell_column, cell_row, text_width, text_height
   output logic        rsp_tuser    // drawn
);

   localparam int CB = COORD_BITS;
   localparam int CNT_BITS = $clog2(CB + 1);
   localparam int OB = tglc437_pkg::OUT_COORD_BITS;
   localparam logic [CB-1:0] CMAX = '1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001, ST_DIV = 5'b00010, ST_MUL = 5'b00100,
      ST_UPD = 5'b01000, ST_OUT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [7:0] tab_ff;
   logic [CB-1:0] col_ff, col_in, row_ff, row_in, mw_ff, mw_in, mh_ff, mh_in;
   logic [tglc437_pkg::CP_BITS-1:0] cp_ff, cp_in;
   logic [CB-1:0] ocol_ff, ocol_in, orow_ff, orow_in;
   logic [7:0] glyph_ff, glyph_in;
   logic drawn_ff, drawn_in;
   logic [CB-1:0] quo_ff, quo_in;
   logic [8:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CB+8:0] prod_ff, prod_in;
   logic [7:0] tw;
   logic [9:0] trial;
   logic [CB:0] inc_col, inc_row;
   logic [CB-1:0] sat_col, sat_row;

   always_comb begin
      tw = (tab_ff == 8'd0) ? 8'd1 : tab_ff;
      trial = {rem_ff, quo_ff[CB-1]} - {2'd0, tw};
      inc_col = {1'b0, ocol_ff} + (CB+1)'(1);
      inc_row = {1'b0, orow_ff} + (CB+1)'(1);
      sat_col = inc_col[CB] ? CMAX : inc_col[CB-1:0];
      sat_row = inc_row[CB] ? CMAX : inc_row[CB-1:0];
   end

   always_comb begin
      state_in = state_ff;
      col_in = col_ff; row_in = row_ff; mw_in = mw_ff; mh_in = mh_ff;
      cp_in = cp_ff; ocol_in = ocol_ff; orow_in = orow_ff;
      glyph_in = glyph_ff; drawn_in = drawn_ff;
      quo_in = quo_ff; rem_in = rem_ff; cnt_in = cnt_ff; prod_in = prod_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cp_in = req_tdata[tglc437_pkg::CP_BITS-1:0];
               ocol_in = req_tuser ? '0 : col_ff;
               orow_in = req_tuser ? '0 : row_ff;
               if (req_tuser) begin
                  mw_in = '0;
                  mh_in = '0;
               end
               quo_in = req_tuser ? '0 : col_ff;
               rem_in = '0;
               cnt_in = CNT_BITS'(CB);
               state_in = (req_tdata[tglc437_pkg::CP_BITS-1:0] == tglc437_pkg::CP_TAB)
                          ? ST_DIV : ST_UPD;
            end
         end
         ST_DIV: begin
            if (!trial[9]) begin
               rem_in = trial[8:0];
               quo_in = {quo_ff[CB-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[7:0], quo_ff[CB-1]};
               quo_in = {quo_ff[CB-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = (CB+9)'({1'b0, quo_ff} + (CB+1)'(1)) * (CB+9)'(tw);
            state_in = ST_UPD;
         end
         ST_UPD: begin
            drawn_in = 1'b0;
            glyph_in = 8'd0;
            case (cp_ff)
               tglc437_pkg::CP_NEWLINE: begin
                  col_in = '0;
                  row_in = sat_row;
               end
               tglc437_pkg::CP_RETURN: begin
                  col_in = '0;
                  row_in = orow_ff;
               end
               tglc437_pkg::CP_TAB: begin
                  col_in = (prod_ff[CB+8:CB] != '0) ? CMAX : prod_ff[CB-1:0];
                  row_in = orow_ff;
               end
               tglc437_pkg::CP_SPACE: begin
                  col_in = sat_col;
                  row_in = orow_ff;
               end
               default: begin
                  drawn_in = 1'b1;
                  glyph_in = tglc437_pkg::to_cp437(cp_ff);
                  col_in = sat_col;
                  row_in = orow_ff;
                  if (sat_col > mw_ff) mw_in = sat_col;
                  if (sat_row > mh_ff) mh_in = sat_row;
               end
            endcase
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tab_ff <= tglc437_pkg::TAB_WIDTH_RESET;
         col_ff <= '0; row_ff <= '0; mw_ff <= '0; mh_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) tab_ff <= csr_wdata;
         col_ff <= col_in; row_ff <= row_in; mw_ff <= mw_in; mh_ff <= mh_in;
      end
      cp_ff <= cp_in; ocol_ff <= ocol_in; orow_ff <= orow_in;
      glyph_ff <= glyph_in; drawn_ff <= drawn_in;
      quo_ff <= quo_in; rem_ff <= rem_in; cnt_ff <= cnt_in; prod_ff <= prod_in;
   end

   function automatic logic [OB-1:0] lo16(input logic [CB-1:0] v);
      logic [OB+CB-1:0] w;
      w = {{OB{1'b0}}, v};
      return w[OB-1:0];
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tuser = drawn_ff;
   assign rsp_tdata = {lo16(mh_ff), lo16(mw_ff), lo16(orow_ff), lo16(ocol_ff), glyph_ff};

endmodule
